>>> hw/rtl/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared widths, byte constants and types of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int CpWidth     = 21;
    localparam int ByteWidth   = 8;
    localparam int CountWidth  = 3;
    localparam int MaxResults  = 4;

    localparam logic [CpWidth-1:0] ReplacementReset = 21'h00FFFD;

    // Lead and continuation byte boundaries.
    localparam logic [7:0] AsciiMax   = 8'h7F;
    localparam logic [7:0] Lead2Min   = 8'hC2;
    localparam logic [7:0] Lead2Max   = 8'hDF;
    localparam logic [7:0] Lead3Min   = 8'hE0;
    localparam logic [7:0] Lead3Max   = 8'hEF;
    localparam logic [7:0] Lead4Min   = 8'hF0;
    localparam logic [7:0] Lead4Max   = 8'hF4;
    localparam logic [7:0] LeadE0     = 8'hE0;
    localparam logic [7:0] LeadEd     = 8'hED;
    localparam logic [7:0] LeadF0     = 8'hF0;
    localparam logic [7:0] LeadF4     = 8'hF4;
    localparam logic [7:0] ContA0     = 8'hA0;
    localparam logic [7:0] Cont90     = 8'h90;
    localparam logic [7:0] Cont8f     = 8'h8F;
    localparam logic [1:0] ContTag    = 2'b10;

    // Results caused by one accepted byte: count replacements, except that the
    // last one carries plain_value when plain is set.
    typedef struct packed {
        logic [CountWidth-1:0] count;
        logic                  plain;
        logic [CpWidth-1:0]    plain_value;
        logic                  eot;
    } usd_step_t;

endpackage

>>> hw/rtl/usd_decode.sv
// ----------------------------------------------------------------------------
// usd_decode
// Sequence state register and the single-pass judgement of one input byte.
// ----------------------------------------------------------------------------
module usd_decode
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [usd_pkg::ByteWidth-1:0]  text_byte,
    input  logic                           end_of_text,
    output usd_pkg::usd_step_t             step
);
    import usd_pkg::*;

    typedef struct packed {
        logic               active;
        logic [1:0]         needed;
        logic [1:0]         seen;
        logic [7:0]         lead;
        logic [CpWidth-1:0] partial_bits;
    } usd_seq_t;

    usd_seq_t seq_reg;
    usd_seq_t seq_next;

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        begin
            ok = 1'b1;
            if (lead == LeadE0)
            begin
                ok = (b >= ContA0);
            end
            else if (lead == LeadEd)
            begin
                ok = (b < ContA0);
            end
            else if (lead == LeadF0)
            begin
                ok = (b >= Cont90);
            end
            else if (lead == LeadF4)
            begin
                ok = (b <= Cont8f);
            end
            return ok;
        end
    endfunction

    always_comb
    begin
        logic                  cont_ok;
        logic                  taken;
        logic                  lead_rep;
        logic [1:0]            seen_inc;
        logic [CpWidth-1:0]    partial_ext;
        logic [CountWidth-1:0] flush_cnt;
        logic [CountWidth-1:0] eot_cnt;

        seq_next    = seq_reg;
        taken       = 1'b0;
        lead_rep    = 1'b0;
        flush_cnt   = '0;
        eot_cnt     = '0;
        seen_inc    = seq_reg.seen + 2'd1;
        partial_ext = {seq_reg.partial_bits[CpWidth-7:0], text_byte[5:0]};
        step        = '0;
        step.eot    = end_of_text;

        cont_ok = (text_byte[7:6] == ContTag) &&
                  ((seq_reg.seen != 2'd0) || second_ok(seq_reg.lead, text_byte));

        // A pending sequence either takes the byte or is flushed.
        if (seq_reg.active)
        begin
            if (cont_ok)
            begin
                taken = 1'b1;
                if (seen_inc >= seq_reg.needed)
                begin
                    step.plain       = 1'b1;
                    step.plain_value = partial_ext;
                    seq_next         = '0;
                end
                else
                begin
                    seq_next.seen         = seen_inc;
                    seq_next.partial_bits = partial_ext;
                end
            end
            else
            begin
                flush_cnt = {1'b0, seq_reg.seen} + 3'd1;
                seq_next  = '0;
            end
        end

        // The byte is judged as a new lead when no sequence took it.
        if (!taken)
        begin
            if (text_byte <= AsciiMax)
            begin
                step.plain       = 1'b1;
                step.plain_value = {{(CpWidth-ByteWidth){1'b0}}, text_byte};
            end
            else if (text_byte inside {[Lead2Min:Lead2Max]})
            begin
                seq_next.active       = 1'b1;
                seq_next.needed       = 2'd1;
                seq_next.seen         = 2'd0;
                seq_next.lead         = text_byte;
                seq_next.partial_bits = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
            end
            else if (text_byte inside {[Lead3Min:Lead3Max]})
            begin
                seq_next.active       = 1'b1;
                seq_next.needed       = 2'd2;
                seq_next.seen         = 2'd0;
                seq_next.lead         = text_byte;
                seq_next.partial_bits = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
            end
            else if (text_byte inside {[Lead4Min:Lead4Max]})
            begin
                seq_next.active       = 1'b1;
                seq_next.needed       = 2'd3;
                seq_next.seen         = 2'd0;
                seq_next.lead         = text_byte;
                seq_next.partial_bits = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
            end
            else
            begin
                lead_rep = 1'b1;
            end
        end

        // End of text flushes whatever is still open.
        if (end_of_text && seq_next.active)
        begin
            eot_cnt  = {1'b0, seq_next.seen} + 3'd1;
            seq_next = '0;
        end

        step.count = flush_cnt + eot_cnt + {2'b00, lead_rep} + {2'b00, step.plain};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
        end
        else if (accept)
        begin
            seq_reg <= seq_next;
        end
    end

    a_needed_set: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.active |-> (seq_reg.needed != 2'd0) && (seq_reg.seen < seq_reg.needed))
        else $error("open sequence with inconsistent counts");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_reg.active |-> (seq_reg == '0))
        else $error("idle sequence state not cleared");

    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> !seq_reg.active)
        else $error("sequence left open after end of text");

endmodule

>>> hw/rtl/usd_burst.sv
// ----------------------------------------------------------------------------
// usd_burst
// Result register playing out a byte's results, one per cycle of out_ready.
// ----------------------------------------------------------------------------
module usd_burst
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  usd_pkg::usd_step_t            step,
    input  logic [usd_pkg::CpWidth-1:0]   replacement_value,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [usd_pkg::CpWidth-1:0]   code_point,
    output logic                          was_replaced,
    output logic                          last_of_run,
    output logic                          text_done
);
    import usd_pkg::*;

    logic [CountWidth-1:0] rem_reg;
    logic [CountWidth-1:0] rem_next;
    logic                  plain_reg;
    logic [CpWidth-1:0]    value_reg;
    logic                  eot_reg;
    logic                  out_fire;

    assign out_valid    = (rem_reg != '0);
    assign out_fire     = out_valid && out_ready;
    assign ready        = (rem_reg == '0) || ((rem_reg == 3'd1) && out_ready);
    assign last_of_run  = (rem_reg == 3'd1);
    assign was_replaced = !(last_of_run && plain_reg);
    assign code_point   = was_replaced ? replacement_value : value_reg;
    assign text_done    = last_of_run && eot_reg;

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = step.count;
        end
        else if (out_fire)
        begin
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plain_reg <= step.plain;
            value_reg <= step.plain_value;
            eot_reg   <= step.eot;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= CountWidth'(MaxResults))
        else $error("result count above maximum");

    a_load_only_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (rem_reg == '0) || ((rem_reg == 3'd1) && out_fire))
        else $error("new word loaded over undelivered results");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !load) |=> (rem_reg == $past(rem_reg) - 3'd1))
        else $error("result count did not step down");

endmodule

>>> hw/rtl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming UTF-8 decoder producing code points, with a programmable
// replacement value for malformed input.
// ----------------------------------------------------------------------------
// Latency: the first result of a byte is presented in the cycle after the byte
// is accepted. Throughput: one byte per cycle while each byte yields at most
// one result and m_axis_tready is high; a byte with several results (up to
// four) holds the input until the result register hands over its last word,
// draining one word per cycle while m_axis_tready is high. Reset clears the
// sequence state and result register and sets the replacement value to U+FFFD.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: replacement value, written whenever cfg_we is high.
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    // Input bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    // Decoded results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // [0] was_replaced, [1] text_done
);
    import usd_pkg::*;

    logic [CpWidth-1:0] replacement_reg;
    logic               in_accept;
    usd_step_t          step;
    logic [CpWidth-1:0] code_point;
    logic               was_replaced;
    logic               text_done;

    // The user must change the replacement value only while the decoder is
    // idle (not enforced). The result register reads it live, no copy per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replacement_reg <= ReplacementReset;
        end
        else if (cfg_we)
        begin
            replacement_reg <= cfg_wdata;
        end
    end

    // A byte is taken whenever the result register is empty or is handing over
    // its final word in this cycle; one-result bytes stall only on the output.
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Judgement of the byte against the open sequence, and the state update.
    usd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .step        (step)
    );

    // Result register: replacements first, a decoded value last where there
    // is one, with the end-of-run and end-of-text marks on the final word.
    usd_burst u_burst
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (in_accept),
        .step              (step),
        .replacement_value (replacement_reg),
        .ready             (s_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .code_point        (code_point),
        .was_replaced      (was_replaced),
        .last_of_run       (m_axis_tlast),
        .text_done         (text_done)
    );

    assign m_axis_tdata = {3'b000, code_point};
    assign m_axis_tuser = {text_done, was_replaced};

endmodule

>>> sim/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Self-checking bench for the UTF-8 stream decoder. A directed run of edge
// bytes and malformed sequences is followed by phases of random text, mostly
// well-formed characters with truncations and noise mixed in. Each phase uses
// its own replacement value. A scoreboard predicts every result word and
// compares it field by field with the output stream, under random gaps on the
// input and random stalls on the output.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;

    import usd_pkg::*;

    localparam int HalfPeriod  = 5;
    localparam int ResetCycles = 10;
    localparam int PhaseCount  = 5;
    localparam int PhaseItems  = 100;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 4;
    localparam int StallLimit  = 2000;
    localparam int ReportLimit = 50;

    localparam logic [7:0]         ContMin    = 8'h80;
    localparam logic [7:0]         ContMax    = 8'hBF;
    localparam logic [CpWidth-1:0] UnicodeMax = 21'h10FFFF;

    // Directed bytes, end of text in bit 8: ASCII extremes, shortest and
    // longest legal forms, each restricted second byte rejected, bad leads,
    // a lone continuation, a truncated sequence cut by a plain byte, and a
    // step that flushes three replacements and then a fourth at end of text.
    localparam logic [8:0] DirectedWords [26] = '{
        9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0E0, 9'h09F, 9'h0ED, 9'h0A0,
        9'h0F0, 9'h08F, 9'h0F4, 9'h090, 9'h0C0, 9'h0FF, 9'h080, 9'h0E1,
        9'h080, 9'h041, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0F1, 9'h080,
        9'h080, 9'h1F1
    };

    typedef enum int {ReadyAlways, ReadyHalf, ReadySparse} ready_mode_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               was_replaced;
        logic               last_of_run;
        logic               text_done;
    } cp_word_t;

    // Predicts the code point words of each accepted byte and checks the
    // output stream against them in order.
    class decode_scoreboard;
        cp_word_t           pending_q[$];
        cp_word_t           run_q[$];
        logic [CpWidth-1:0] replacement;
        logic               seq_open;
        logic [1:0]         cont_needed;
        logic [1:0]         cont_seen;
        logic [7:0]         lead_byte;
        logic [CpWidth-1:0] payload;
        int                 errors;

        function new();
            replacement = ReplacementReset;
            errors = 0;
            close_seq();
        endfunction

        function void close_seq();
            seq_open = 1'b0;
            cont_needed = 2'd0;
            cont_seen = 2'd0;
            lead_byte = 8'd0;
            payload = '0;
        endfunction

        function void start_seq(logic [1:0] needed, logic [7:0] lead, logic [CpWidth-1:0] bits);
            seq_open = 1'b1;
            cont_needed = needed;
            cont_seen = 2'd0;
            lead_byte = lead;
            payload = bits;
        endfunction

        function void add_result(logic [CpWidth-1:0] cp, logic replaced);
            cp_word_t w;
            w.code_point = cp;
            w.was_replaced = replaced;
            w.last_of_run = 1'b0;
            w.text_done = 1'b0;
            if (run_q.size() < MaxResults)
                run_q = {run_q, w};
        endfunction

        // One replacement for the lead and one per continuation taken.
        function void reject_seq();
            for (int k = 0; k <= int'(cont_seen) && k < 3; k++)
                add_result(replacement, 1'b1);
            close_seq();
        endfunction

        function void note_byte(logic [7:0] b, logic eot);
            logic     taken;
            logic     ok;
            cp_word_t w;
            run_q.delete();
            taken = 1'b0;
            if (seq_open)
            begin
                ok = (b[7:6] == ContTag);
                if (ok && cont_seen == 2'd0)
                begin
                    if (lead_byte == LeadE0)
                        ok = (b >= ContA0);
                    else if (lead_byte == LeadEd)
                        ok = (b < ContA0);
                    else if (lead_byte == LeadF0)
                        ok = (b >= Cont90);
                    else if (lead_byte == LeadF4)
                        ok = (b <= Cont8f);
                end
                if (ok)
                begin
                    payload = {payload[CpWidth-7:0], b[5:0]};
                    cont_seen = cont_seen + 2'd1;
                    taken = 1'b1;
                    if (cont_seen >= cont_needed)
                    begin
                        add_result(payload, 1'b0);
                        close_seq();
                    end
                end
                else
                    reject_seq();
            end
            // A byte not taken as a continuation is judged as a new lead.
            if (!taken)
            begin
                if (b <= AsciiMax)
                    add_result(CpWidth'(b), 1'b0);
                else if (b >= Lead2Min && b <= Lead2Max)
                    start_seq(2'd1, b, CpWidth'(b[4:0]));
                else if (b >= Lead3Min && b <= Lead3Max)
                    start_seq(2'd2, b, CpWidth'(b[3:0]));
                else if (b >= Lead4Min && b <= Lead4Max)
                    start_seq(2'd3, b, CpWidth'(b[2:0]));
                else
                    add_result(replacement, 1'b1);
            end
            if (eot && seq_open)
                reject_seq();
            foreach (run_q[k])
            begin
                w = run_q[k];
                w.last_of_run = (k == run_q.size() - 1);
                w.text_done = w.last_of_run & eot;
                pending_q = {pending_q, w};
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                if (errors < ReportLimit)
                    $display("%0t: %s expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [23:0] data, logic last, logic [1:0] user);
            cp_word_t w;
            if (pending_q.size() == 0)
            begin
                if (errors < ReportLimit)
                    $display("%0t: unexpected word, expected none, got data %h last %b user %b",
                             $time, data, last, user);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            compare_field("code_point", 32'(w.code_point), 32'(data[CpWidth-1:0]));
            compare_field("tdata padding", 32'd0, 32'(data[23:CpWidth]));
            compare_field("was_replaced", 32'(w.was_replaced), 32'(user[0]));
            compare_field("last_of_run", 32'(w.last_of_run), 32'(last));
            compare_field("text_done", 32'(w.text_done), 32'(user[1]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;  // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [20:0] code_point, [23:21] zero
    logic        m_axis_tlast;         // last_of_run
    logic [1:0]  m_axis_tuser;         // [0] was_replaced, [1] text_done

    decode_scoreboard sb = new();
    logic [7:0]       char_bytes[$];
    int               burst_left = 0;
    int               quiet_cycles = 0;
    bit               holdoff_request = 1'b0;

    utf8_stream_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HalfPeriod clk = ~clk;

    // Offers one byte, opening a new burst with a random gap when the last
    // one is used up, and waits until the decoder takes it.
    task automatic push_byte(logic [7:0] b, logic eot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eot;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_byte(b, eot);
    endtask

    // Stops sending and waits for every predicted word, plus the decoder's
    // latency, so that the register can be written while it is idle.
    task automatic pause_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_replacement(logic [CpWidth-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.replacement = value;
    endtask

    function automatic logic [7:0] random_lead();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(Lead2Min, Lead2Max));
            1:       return 8'($urandom_range(Lead3Min, Lead3Max));
            default: return 8'($urandom_range(Lead4Min, Lead4Max));
        endcase
    endfunction

    // Builds a whole multi-byte character behind the given lead. With strict
    // set, the second byte keeps to the range that the lead allows.
    function automatic void build_char(logic [7:0] lead, bit strict);
        int         len;
        logic [7:0] lo;
        logic [7:0] hi;
        len = (lead >= Lead4Min) ? 4 : (lead >= Lead3Min) ? 3 : 2;
        lo = ContMin;
        hi = ContMax;
        if (strict)
        begin
            if (lead == LeadE0)
                lo = ContA0;
            else if (lead == LeadEd)
                hi = ContA0 - 8'd1;
            else if (lead == LeadF0)
                lo = Cont90;
            else if (lead == LeadF4)
                hi = Cont8f;
        end
        char_bytes.delete();
        char_bytes = {char_bytes, lead};
        char_bytes = {char_bytes, 8'($urandom_range(lo, hi))};
        for (int k = 2; k < len; k++)
            char_bytes = {char_bytes, {ContTag, 6'($urandom_range(0, 63))}};
    endfunction

    // Random text: mostly whole characters, some cut short, some behind the four
    // restricted leads with an unrestricted second byte, and some arbitrary bytes.
    task automatic send_random_text(int count);
        int         sent;
        int         pick;
        int         cut;
        logic       eot;
        logic [7:0] lead;
        sent = 0;
        while (sent < count)
        begin
            char_bytes.delete();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                char_bytes = {char_bytes, 8'($urandom_range(0, AsciiMax))};
            else if (pick < 70)
                build_char(random_lead(), 1'b1);
            else if (pick < 80)
            begin
                build_char(random_lead(), 1'b1);
                cut = $urandom_range(1, char_bytes.size() - 1);
                while (char_bytes.size() > cut)
                    void'(char_bytes.pop_back());
            end
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0:       lead = LeadE0;
                    1:       lead = LeadEd;
                    2:       lead = LeadF0;
                    default: lead = LeadF4;
                endcase
                build_char(lead, 1'b0);
            end
            else
                char_bytes = {char_bytes, 8'($urandom_range(0, 255))};
            eot = ($urandom_range(0, 15) == 0);
            foreach (char_bytes[i])
            begin
                push_byte(char_bytes[i], eot && (i == char_bytes.size() - 1));
                sent++;
            end
        end
    endtask

    // Output side: ready follows a mode that changes now and then, and once
    // it is held low for a long stretch so that the decoder backs up.
    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        mode = ReadyAlways;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                ReadyAlways: m_axis_tready <= 1'b1;
                ReadyHalf:   m_axis_tready <= 1'($urandom_range(0, 1));
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [CpWidth-1:0] phase_value;
        int                 phase;
        repeat (ResetCycles) @(negedge clk);
        rst_n = 1'b1;

        // Directed bytes run with the replacement value left at its reset.
        foreach (DirectedWords[i])
            push_byte(DirectedWords[i][7:0], DirectedWords[i][8]);
        pause_until_drained();

        for (phase = 0; phase < PhaseCount; phase++)
        begin
            case (phase)
                0:       phase_value = '0;
                1:       phase_value = '1;
                2:       phase_value = UnicodeMax;
                default: phase_value = CpWidth'($urandom_range(0, 21'h1FFFFF));
            endcase
            write_replacement(phase_value);
            if (phase == 1)
                holdoff_request = 1'b1;
            send_random_text(PhaseItems);
            pause_until_drained();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/usd_pkg.sv
hw/rtl/usd_decode.sv
hw/rtl/usd_burst.sv
hw/rtl/utf8_stream_decoder_core.sv
sim/utf8_stream_decoder_core_tb.sv
